@@ hdl/mavf_pkg.sv @@
// Shared constants, types and state codes for the moving average filter.
// No dependencies; mavf_divider and moving_average_filter_core import this package.
package mavf_pkg;

   localparam int WINDOW_MAX = 64;
   localparam int SAMPLE_W   = 16;
   localparam int SUM_W      = 22;
   localparam int LEN_W      = 7;
   localparam int IDX_W      = $clog2(WINDOW_MAX);
   localparam int CNT_W      = $clog2(SUM_W);
   localparam int RSP_W      = ((SAMPLE_W + SUM_W + 7) / 8) * 8;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_DIVIDE,
      ST_DRAIN
   } state_type;

   typedef struct packed {
      logic                    start;
      logic signed [SUM_W-1:0] dividend;
      logic [LEN_W-1:0]        divisor;
   } div_req_type;

   typedef struct packed {
      logic                       done;
      logic signed [SAMPLE_W-1:0] average;
   } div_rsp_type;

endpackage

@@ hdl/mavf_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module mavf_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/mavf_divider.sv @@
// Iterative restoring divider: signed window sum by window length, one
// quotient bit per cycle, truncation toward zero, saturated to 16 bits.
// Depends on mavf_pkg.
module mavf_divider
   import mavf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [LEN_W-1:0] rem_ff, rem_in;
   logic [SUM_W-1:0] quo_ff, quo_in;
   logic             neg_ff, neg_in;
   logic [LEN_W-1:0] divisor_ff, divisor_in;

   logic [LEN_W:0]   trial;
   logic [LEN_W:0]   diff;
   logic             ge;
   logic signed [SUM_W:0] quo_signed;

   always_comb begin
      trial = {rem_ff, quo_ff[SUM_W-1]};
      diff  = trial - {1'b0, divisor_ff};
      ge    = (trial >= {1'b0, divisor_ff});

      busy_in    = busy_ff;
      done_in    = 1'b0;
      count_in   = count_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      neg_in     = neg_ff;
      divisor_in = divisor_ff;

      if (div_req.start) begin
         busy_in    = 1'b1;
         count_in   = '0;
         rem_in     = '0;
         neg_in     = div_req.dividend[SUM_W-1];
         quo_in     = div_req.dividend[SUM_W-1] ? SUM_W'(-div_req.dividend)
                                                : SUM_W'(div_req.dividend);
         divisor_in = div_req.divisor;
      end else if (busy_ff) begin
         // remainder stays below the divisor, so it fits LEN_W bits
         rem_in   = ge ? diff[LEN_W-1:0] : trial[LEN_W-1:0];
         quo_in   = {quo_ff[SUM_W-2:0], ge};
         count_in = count_ff + CNT_W'(1);
         if (count_ff == CNT_W'(SUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      neg_ff     <= neg_in;
      divisor_ff <= divisor_in;
   end

   always_comb begin
      quo_signed = neg_ff ? -$signed({1'b0, quo_ff}) : $signed({1'b0, quo_ff});
      div_rsp.done = done_ff;
      priority if (quo_signed > $signed((SUM_W+1)'(32767))) begin
         div_rsp.average = 16'sh7FFF;
      end else if (quo_signed < -$signed((SUM_W+1)'(32768))) begin
         div_rsp.average = 16'sh8000;
      end else begin
         div_rsp.average = quo_signed[SAMPLE_W-1:0];
      end
   end

endmodule

@@ hdl/moving_average_filter_core.sv @@
// Moving average filter core: sample ring in RAM, running sum, divider.
// Depends on mavf_pkg, mavf_ram and mavf_divider.
//
// Usage:
//   req_* carries one signed 16-bit sample per transfer. rsp_* returns one
//   result per sample: the average (window sum / window length, truncated
//   toward zero) and the window sum. csr_wr_en/csr_wdata set the window
//   length (0 reads as 1, above 64 as 64) and clear the ring, index and sum.
//   Write the length only while no sample is in flight.
//
// Sequence:
//   Ring read at the input transfer, sum update and write-back in
//   ST_UPDATE, divider iterations in ST_DIVIDE, then the hand-off state
//   ST_DRAIN loads the output register. One sample in flight at a time;
//   req_tready returns only once the state machine is back in ST_IDLE.
//
// Reset clears the window length to 16 and empties the ring (per-entry
// valid bits). If rsp_tready stays low, the finished result waits in the
// output register; the next sample is taken meanwhile and waits in the
// hand-off state until the output register frees up.
module moving_average_filter_core
   import mavf_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [15:0]      req_tdata,   // [15:0] sample
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata,   // [15:0] average, [37:16] window_sum, zero pad
   input  logic             csr_wr_en,
   input  logic [LEN_W-1:0] csr_wdata
);

   state_type               state_ff, state_in;
   logic [WINDOW_MAX-1:0]   valid_ff, valid_in;
   logic [IDX_W-1:0]        index_ff, index_in;
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic [LEN_W-1:0]        len_ff, len_in;
   logic signed [SAMPLE_W-1:0] sample_ff, sample_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0] rsp_avg_ff, rsp_avg_in;
   logic signed [SUM_W-1:0] rsp_sum_ff, rsp_sum_in;

   logic                    accept;
   logic                    ring_wr_en;
   logic [SAMPLE_W-1:0]     ring_rd_data;
   logic [SAMPLE_W-1:0]     evicted;
   logic signed [SUM_W-1:0] sum_new;
   logic [LEN_W-1:0]        len_sat;
   div_req_type             div_req;
   div_rsp_type             div_rsp;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign ring_wr_en = (state_ff == ST_UPDATE);

   mavf_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (WINDOW_MAX)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ring_wr_en),
      .wr_addr (index_ff),
      .wr_data (sample_ff),
      .rd_en   (accept),
      .rd_addr (index_ff),
      .rd_data (ring_rd_data)
   );

   mavf_divider u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // never-written slots read as zero
   assign evicted = valid_ff[index_ff] ? ring_rd_data : '0;
   assign sum_new = sum_ff
                  + {{(SUM_W-SAMPLE_W){sample_ff[SAMPLE_W-1]}}, sample_ff}
                  - {{(SUM_W-SAMPLE_W){evicted[SAMPLE_W-1]}}, evicted};

   always_comb begin
      div_req.start    = ring_wr_en;
      div_req.dividend = sum_new;
      div_req.divisor  = len_ff;
   end

   always_comb begin
      priority if (csr_wdata == '0) begin
         len_sat = LEN_W'(1);
      end else if (csr_wdata > LEN_W'(WINDOW_MAX)) begin
         len_sat = LEN_W'(WINDOW_MAX);
      end else begin
         len_sat = csr_wdata;
      end
   end

   always_comb begin
      state_in     = state_ff;
      valid_in     = valid_ff;
      index_in     = index_ff;
      sum_in       = sum_ff;
      len_in       = len_ff;
      sample_in    = sample_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_avg_in   = rsp_avg_ff;
      rsp_sum_in   = rsp_sum_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               sample_in = req_tdata;
               state_in  = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            sum_in             = sum_new;
            valid_in[index_ff] = 1'b1;
            if ((LEN_W'(index_ff) + LEN_W'(1)) == len_ff) begin
               index_in = '0;
            end else begin
               index_in = index_ff + IDX_W'(1);
            end
            state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (div_rsp.done) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_avg_in   = div_rsp.average;
               rsp_sum_in   = sum_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (csr_wr_en) begin
         len_in   = len_sat;
         valid_in = '0;
         index_in = '0;
         sum_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         index_ff     <= '0;
         sum_ff       <= '0;
         len_ff       <= LEN_W'(16);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         index_ff     <= index_in;
         sum_ff       <= sum_in;
         len_ff       <= len_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sample_ff  <= sample_in;
      rsp_avg_ff <= rsp_avg_in;
      rsp_sum_ff <= rsp_sum_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_W-SAMPLE_W-SUM_W){1'b0}}, rsp_sum_ff, rsp_avg_ff};

endmodule
